FILE: sv/tick_to_ohlcv_bar_aggregator_top_macros.svh
// Assertion helpers used by the aggregator top module.
`ifndef TICK_TO_OHLCV_BAR_AGGREGATOR_TOP_MACROS_SVH
`define TICK_TO_OHLCV_BAR_AGGREGATOR_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TOHLCV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("aggregator check failed");

// An implication that must hold at every clock edge outside reset.
`define TOHLCV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aggregator check failed");

`endif

FILE: sv/tohlcv_pkg.sv
`timescale 1ns / 1ps
package tohlcv_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int NUM_FRAMES  = 5;
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int ENTRIES     = MAX_SYMBOLS * NUM_FRAMES;
  localparam int ENTRY_AW    = $clog2(ENTRIES);

  localparam int PRICE_W  = 32;
  localparam int VOL_W    = 48;
  localparam int MS_W     = 47;
  localparam int SECS_W   = 37;
  localparam int DUR_W    = 17;
  localparam int SYMCNT_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W    = 6;

  localparam logic [DUR_W-1:0] MS_PER_SEC = DUR_W'(1000);

  // Milliseconds are divided by 1000 one 16-bit chunk at a time. MS_RECIP is
  // ceil(2^36 / 1000), which gives the exact quotient of every partial value
  // below 1000 * 2^16.
  localparam int MS_CHUNK_W = 16;
  localparam int MS_CHUNKS  = 3;
  localparam int MS_REM_W   = 10;
  localparam int MS_VAL_W   = MS_REM_W + MS_CHUNK_W;
  localparam int MS_QUO_W   = MS_CHUNKS * MS_CHUNK_W;
  localparam int MS_RECIP_W = 27;
  localparam int MS_SHIFT   = 36;
  localparam int MS_PROD_W  = MS_VAL_W + MS_RECIP_W;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(68719477);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOLS = 3'd0,
    REG_FRAME0  = 3'd1,
    REG_FRAME1  = 3'd2,
    REG_FRAME2  = 3'd3,
    REG_FRAME3  = 3'd4,
    REG_FRAME4  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOL,
    S_DIV_MS,
    S_DIV_FR,
    S_UPD
  } state_e;

  typedef struct packed {
    logic [5:0]  symbol_id;
    logic [31:0] price;
    logic [47:0] cumulative_volume;
    logic [46:0] exchange_ms;
    logic [36:0] wall_seconds;
  } tick_t;

  typedef struct packed {
    logic [5:0]  out_symbol;
    logic [2:0]  frame_index;
    logic [36:0] bar_start;
    logic [31:0] bar_open;
    logic [31:0] bar_high;
    logic [31:0] bar_low;
    logic [31:0] bar_close;
    logic [47:0] bar_volume;
    logic        opened_new;
    logic        publish_closed;
    logic [36:0] closed_start;
    logic        last_of_run;
  } bar_t;

  typedef struct packed {
    logic [SECS_W-1:0]  start;
    logic [PRICE_W-1:0] open;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] close;
    logic [VOL_W-1:0]   volume;
  } entry_t;

endpackage

FILE: sv/tohlcv_ram.sv
`timescale 1ns / 1ps
module tohlcv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tick_to_ohlcv_bar_aggregator_top.sv
`timescale 1ns / 1ps
// Tick to OHLCV bar aggregator.
// A tick word is taken on tick when start is high and busy is low. Ticks of a
// symbol at or above symbols_in_use are taken and dropped; busy stays low.
// The first tick of a symbol records its volume and gives no result. Every
// later tick gives five result words on bar, one per timeframe in order,
// each marked by strobe for a single cycle; the last carries last_of_run.
// The receiver cannot stall, so results simply appear at their cycle.
// Steps: the volume state takes the read of the volume memory, then milliseconds
// are turned into seconds, 16 bits per cycle by reciprocal multiplication
// (skipped when exchange time is absent). Each timeframe then takes a pass
// of a bit-serial divider for its bar start and one read-modify-write step on
// the bar memory; its word is registered and follows in the next cycle.
// A tick keeps busy high until its last bar update, and a new tick can be
// taken at the edge that ends the cycle of the last result word.
// Configuration words on cfg_we/cfg_index/cfg_data take effect at once and
// belong to idle periods.
// Reset (rst, synchronous) restores the default registers and marks every
// symbol as unseen; no clearing pass is needed, the memories hold no state
// that is read before it is written.
module tick_to_ohlcv_bar_aggregator_top import tohlcv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tick_t                tick,
  output logic                 strobe,
  output bar_t                 bar,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  `include "tick_to_ohlcv_bar_aggregator_top_macros.svh"

  state_e state, state_next;

  logic [SYMCNT_W-1:0] symbols_in_use;
  logic [DUR_W-1:0]    frame_secs [NUM_FRAMES];
  logic [MAX_SYMBOLS-1:0] vol_seen;
  logic [MAX_SYMBOLS-1:0] bar_ok;

  tick_t             tk;
  logic [VOL_W-1:0]  inc;
  logic [SECS_W-1:0] secs;
  logic [2:0]        frame;
  logic [MS_W-1:0]   dvd;
  logic [DUR_W-1:0]  rem;
  logic [DUR_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic              load_fr;
  logic [DUR_W:0]    trial;
  logic              qbit;
  logic [DUR_W-1:0]  fr_dur;
  logic [2:0]        frame_ld;
  logic [SECS_W-1:0] fr_secs;

  logic [MS_CHUNK_W-1:0] ms_chunk;
  logic [MS_VAL_W-1:0]   ms_val;
  logic [MS_PROD_W-1:0]  ms_prod;
  logic [MS_CHUNK_W-1:0] ms_q;
  logic [MS_VAL_W-1:0]   ms_back;
  logic [MS_VAL_W-1:0]   ms_diff;
  logic [DUR_W-1:0]      ms_rem;
  logic [MS_QUO_W-1:0]   quo;
  logic [MS_QUO_W-1:0]   ms_quo;
  logic [SECS_W-1:0]     ms_secs;

  logic [VOL_W-1:0]  lv_rdata;
  logic              lv_we;
  logic [SYM_W-1:0]  lv_raddr;

  logic [ENTRY_AW-1:0] bar_addr;
  logic [$bits(entry_t)-1:0] u_bar_rdata;
  entry_t            cur, upd;
  logic              bar_we;
  logic [SECS_W-1:0] start_new;
  logic              open_new;
  logic [VOL_W:0]    vsum;
  bar_t              res_next;
  logic [VOL_W-1:0]  inc_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_in_use <= SYMCNT_W'(64);
      frame_secs[0]  <= DUR_W'(60);
      frame_secs[1]  <= DUR_W'(180);
      frame_secs[2]  <= DUR_W'(300);
      frame_secs[3]  <= DUR_W'(900);
      frame_secs[4]  <= DUR_W'(1800);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYMBOLS: symbols_in_use <= cfg_data[SYMCNT_W-1:0];
        REG_FRAME0:  frame_secs[0] <= cfg_data;
        REG_FRAME1:  frame_secs[1] <= cfg_data;
        REG_FRAME2:  frame_secs[2] <= cfg_data;
        REG_FRAME3:  frame_secs[3] <= cfg_data;
        REG_FRAME4:  frame_secs[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last cumulative volume per symbol.
  assign lv_raddr = (state == S_IDLE) ? tick.symbol_id : tk.symbol_id;
  assign lv_we    = (state == S_VOL) &&
                    (!vol_seen[tk.symbol_id] || tk.cumulative_volume != '0);

  tohlcv_ram #(.WIDTH(VOL_W), .DEPTH(MAX_SYMBOLS)) u_last_vol (
    .clk   (clk),
    .we    (lv_we),
    .waddr (tk.symbol_id),
    .wdata (tk.cumulative_volume),
    .raddr (lv_raddr),
    .rdata (lv_rdata)
  );

  // Bar memory, one word per symbol and timeframe.
  assign bar_addr = ENTRY_AW'(tk.symbol_id) * ENTRY_AW'(NUM_FRAMES) + ENTRY_AW'(frame);
  assign bar_we   = (state == S_UPD);
  assign cur      = entry_t'(u_bar_rdata);

  tohlcv_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_bar (
    .clk   (clk),
    .we    (bar_we),
    .waddr (bar_addr),
    .wdata (upd),
    .raddr (bar_addr),
    .rdata (u_bar_rdata)
  );

  // Restoring divider step; the remainder never reaches the divisor.
  assign trial = {rem, dvd[MS_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  // The divider is loaded for frame 0 out of the volume and millisecond
  // states, and for the following frame out of the update state.
  assign frame_ld = (state == S_VOL) ? 3'd0 : (state == S_UPD) ? frame + 3'd1 : frame;
  assign fr_dur   = (frame_secs[frame_ld] == '0) ? DUR_W'(1) : frame_secs[frame_ld];
  assign fr_secs  = (state == S_VOL) ? tk.wall_seconds :
                    (state == S_DIV_MS) ? ms_secs : secs;

  // Milliseconds to seconds, most significant chunk first; the remainder of
  // one chunk is carried into the next.
  always_comb begin
    case (cnt)
      CNT_W'(3): ms_chunk = MS_CHUNK_W'(tk.exchange_ms[MS_W-1:2*MS_CHUNK_W]);
      CNT_W'(2): ms_chunk = tk.exchange_ms[2*MS_CHUNK_W-1:MS_CHUNK_W];
      default:   ms_chunk = tk.exchange_ms[MS_CHUNK_W-1:0];
    endcase
    ms_val  = {rem[MS_REM_W-1:0], ms_chunk};
    ms_prod = MS_PROD_W'(ms_val) * MS_PROD_W'(MS_RECIP);
    ms_q    = ms_prod[MS_SHIFT +: MS_CHUNK_W];
    ms_back = MS_VAL_W'(ms_q) * MS_VAL_W'(MS_PER_SEC);
    ms_diff = ms_val - ms_back;
    ms_rem  = DUR_W'(ms_diff[MS_REM_W-1:0]);
    ms_quo  = {quo[MS_QUO_W-MS_CHUNK_W-1:0], ms_q};
    // Quotient saturates at the widest second count.
    ms_secs = (ms_quo[MS_QUO_W-1:SECS_W] != '0) ? '1 : ms_quo[SECS_W-1:0];
  end

  // Volume increment, clamped at zero, and zero while the stored volume is zero.
  always_comb begin
    inc_next = '0;
    if (lv_rdata != '0 && tk.cumulative_volume > lv_rdata) begin
      inc_next = tk.cumulative_volume - lv_rdata;
    end
  end

  // Bar update.
  always_comb begin
    start_new = secs - SECS_W'(rem);
    open_new  = !bar_ok[tk.symbol_id] || (cur.start < start_new);
    vsum      = {1'b0, cur.volume} + {1'b0, inc};
    upd       = cur;
    if (open_new) begin
      upd.start  = start_new;
      upd.open   = tk.price;
      upd.high   = tk.price;
      upd.low    = tk.price;
      upd.close  = tk.price;
      upd.volume = inc;
    end else begin
      if (tk.price > cur.high) begin
        upd.high = tk.price;
      end
      if (tk.price < cur.low) begin
        upd.low = tk.price;
      end
      upd.close  = tk.price;
      upd.volume = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
    end
    res_next.out_symbol     = tk.symbol_id;
    res_next.frame_index    = frame;
    res_next.bar_start      = upd.start;
    res_next.bar_open       = upd.open;
    res_next.bar_high       = upd.high;
    res_next.bar_low        = upd.low;
    res_next.bar_close      = upd.close;
    res_next.bar_volume     = upd.volume;
    res_next.opened_new     = open_new;
    res_next.publish_closed = open_new && bar_ok[tk.symbol_id] && (frame == '0);
    res_next.closed_start   = res_next.publish_closed ? cur.start : '0;
    res_next.last_of_run    = (frame == 3'(NUM_FRAMES - 1));
  end

  // Next state.
  always_comb begin
    state_next = state;
    load_fr    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && ({1'b0, tick.symbol_id} < symbols_in_use)) begin
          state_next = S_VOL;
        end
      end
      S_VOL: begin
        if (!vol_seen[tk.symbol_id]) begin
          state_next = S_IDLE;
        end else if (tk.exchange_ms != '0) begin
          state_next = S_DIV_MS;
        end else begin
          state_next = S_DIV_FR;
          load_fr    = 1'b1;
        end
      end
      S_DIV_MS: begin
        if (cnt == CNT_W'(1)) begin
          state_next = S_DIV_FR;
          load_fr    = 1'b1;
        end
      end
      S_DIV_FR: begin
        if (cnt == CNT_W'(1)) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (frame == 3'(NUM_FRAMES - 1)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DIV_FR;
          load_fr    = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vol_seen <= '0;
      bar_ok   <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_UPD);
      if (state == S_VOL) begin
        vol_seen[tk.symbol_id] <= 1'b1;
      end
      if (state == S_UPD && res_next.last_of_run) begin
        bar_ok[tk.symbol_id] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      tk <= tick;
    end
    if (state == S_VOL) begin
      inc   <= (tk.cumulative_volume != '0) ? inc_next : '0;
      frame <= '0;
      secs  <= tk.wall_seconds;
    end
    if (state == S_DIV_MS && cnt == CNT_W'(1)) begin
      secs <= ms_secs;
    end
    if (state == S_UPD) begin
      bar   <= res_next;
      frame <= frame + 3'd1;
    end
    if (load_fr) begin
      rem     <= '0;
      cnt     <= CNT_W'(SECS_W);
      divisor <= fr_dur;
      dvd     <= {fr_secs, {(MS_W - SECS_W){1'b0}}};
    end else if (state == S_VOL) begin
      rem     <= '0;
      cnt     <= CNT_W'(MS_CHUNKS);
      divisor <= MS_PER_SEC;
    end else if (state == S_DIV_MS) begin
      rem <= ms_rem;
      quo <= ms_quo;
      cnt <= cnt - CNT_W'(1);
    end else if (state == S_DIV_FR) begin
      rem <= qbit ? DUR_W'(trial - {1'b0, divisor}) : trial[DUR_W-1:0];
      dvd <= {dvd[MS_W-2:0], qbit};
      cnt <= cnt - CNT_W'(1);
    end
  end

  `TOHLCV_ASSERT_IMPL(a_last_ends_run, strobe && bar.last_of_run, state == S_IDLE)
  `TOHLCV_ASSERT_IMPL(a_frame_range, strobe, bar.frame_index < 3'(NUM_FRAMES))
  `TOHLCV_ASSERT_IMPL(a_div_nonzero, state == S_DIV_MS || state == S_DIV_FR, divisor != '0)
  `TOHLCV_ASSERT_IMPL(a_publish_frame0, strobe && bar.publish_closed,
                      bar.frame_index == '0 && bar.opened_new)

endmodule

FILE: sim/tick_to_ohlcv_bar_aggregator_top_tb.sv
`timescale 1ns / 1ps
module tick_to_ohlcv_bar_aggregator_top_tb;
  import tohlcv_pkg::*;

  localparam int  SETTLE_CYCLES = 400;
  localparam int  CYCLE_LIMIT   = 3000000;
  localparam logic [47:0] VOL_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [36:0] SECS_MAX = 37'h1F_FFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  tick_t                tick = '0;
  logic                 strobe;
  bar_t                 bar;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data = '0;

  tick_to_ohlcv_bar_aggregator_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .tick(tick),
    .strobe(strobe), .bar(bar), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and memories.
  logic [SYMCNT_W-1:0] symbols_used;
  logic [DUR_W-1:0]    frame_dur [NUM_FRAMES];
  bit                  vol_seen [MAX_SYMBOLS];
  logic [VOL_W-1:0]    prev_cum [MAX_SYMBOLS];
  bit                  bar_live [MAX_SYMBOLS][NUM_FRAMES];
  entry_t              bar_mem [MAX_SYMBOLS][NUM_FRAMES];

  bar_t expected_bars[$];
  int   errors = 0;
  int   cycles = 0;
  bit   idle_on = 1'b1;

  // Stimulus state: a clock that mostly moves forward and per-symbol volume.
  logic [36:0] market_secs = 37'd1000000;
  logic [47:0] day_volume [MAX_SYMBOLS];

  function automatic void predict_bars(tick_t t);
    logic [63:0] inc, secs, dur, bstart, vsum;
    bar_t b;
    int s;
    s = t.symbol_id;
    if (t.symbol_id >= symbols_used) return;
    if (!vol_seen[s]) begin
      vol_seen[s] = 1'b1;
      prev_cum[s] = t.cumulative_volume;
      return;
    end
    inc = '0;
    if (t.cumulative_volume != 0) begin
      if (prev_cum[s] != 0 && t.cumulative_volume > prev_cum[s])
        inc = 64'(t.cumulative_volume - prev_cum[s]);
      prev_cum[s] = t.cumulative_volume;
    end
    secs = (t.exchange_ms != 0) ? 64'(t.exchange_ms) / 64'd1000 : 64'(t.wall_seconds);
    if (secs > 64'(SECS_MAX)) secs = 64'(SECS_MAX);
    for (int f = 0; f < NUM_FRAMES; f++) begin
      b = '0;
      dur = (frame_dur[f] != 0) ? 64'(frame_dur[f]) : 64'd1;
      bstart = (secs / dur) * dur;
      if (!bar_live[s][f] || 64'(bar_mem[s][f].start) < bstart) begin
        if (bar_live[s][f] && f == 0) begin
          b.publish_closed = 1'b1;
          b.closed_start = bar_mem[s][f].start;
        end
        b.opened_new = 1'b1;
        bar_live[s][f] = 1'b1;
        bar_mem[s][f] = '{start: bstart[36:0], open: t.price, high: t.price,
                          low: t.price, close: t.price, volume: inc[47:0]};
      end else begin
        vsum = 64'(bar_mem[s][f].volume) + inc;
        if (t.price > bar_mem[s][f].high) bar_mem[s][f].high = t.price;
        if (t.price < bar_mem[s][f].low) bar_mem[s][f].low = t.price;
        bar_mem[s][f].close = t.price;
        bar_mem[s][f].volume = (vsum > 64'(VOL_MAX)) ? VOL_MAX : vsum[47:0];
      end
      b.out_symbol = t.symbol_id;
      b.frame_index = 3'(f);
      b.bar_start = bar_mem[s][f].start;
      b.bar_open = bar_mem[s][f].open;
      b.bar_high = bar_mem[s][f].high;
      b.bar_low = bar_mem[s][f].low;
      b.bar_close = bar_mem[s][f].close;
      b.bar_volume = bar_mem[s][f].volume;
      b.last_of_run = (f == NUM_FRAMES - 1);
      expected_bars = {expected_bars, b};
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bar_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d bars outstanding", expected_bars.size());
      $display("== FAIL ==");
      $finish;
    end else if (!rst && strobe === 1'b1) begin
      if (expected_bars.size() == 0) begin
        errors++;
        $display("%0t: unexpected bar word, expected none, got %h", $time, bar);
      end else begin
        e = expected_bars.pop_front();
        check_field("out_symbol", 64'(e.out_symbol), 64'(bar.out_symbol));
        check_field("frame_index", 64'(e.frame_index), 64'(bar.frame_index));
        check_field("bar_start", 64'(e.bar_start), 64'(bar.bar_start));
        check_field("bar_open", 64'(e.bar_open), 64'(bar.bar_open));
        check_field("bar_high", 64'(e.bar_high), 64'(bar.bar_high));
        check_field("bar_low", 64'(e.bar_low), 64'(bar.bar_low));
        check_field("bar_close", 64'(e.bar_close), 64'(bar.bar_close));
        check_field("bar_volume", 64'(e.bar_volume), 64'(bar.bar_volume));
        check_field("opened_new", 64'(e.opened_new), 64'(bar.opened_new));
        check_field("publish_closed", 64'(e.publish_closed), 64'(bar.publish_closed));
        check_field("closed_start", 64'(e.closed_start), 64'(bar.closed_start));
        check_field("last_of_run", 64'(e.last_of_run), 64'(bar.last_of_run));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_tick(tick_t t);
    if (idle_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    start <= 1'b1;
    tick <= t;
    do @(posedge clk); while (busy !== 1'b0);
    predict_bars(t);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_bars.size() != 0) @(negedge clk);
    // A dropped or first tick may still be in flight with nothing expected.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DUR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYMBOLS) symbols_used = val[SYMCNT_W-1:0];
    else frame_dur[int'(idx) - 1] = val;
  endtask

  task automatic write_frames(int d0, int d1, int d2, int d3, int d4);
    write_reg(REG_FRAME0, DUR_W'(d0));
    write_reg(REG_FRAME1, DUR_W'(d1));
    write_reg(REG_FRAME2, DUR_W'(d2));
    write_reg(REG_FRAME3, DUR_W'(d3));
    write_reg(REG_FRAME4, DUR_W'(d4));
  endtask

  function automatic tick_t make_tick(logic [5:0] sym, logic [31:0] px,
                                      logic [47:0] cum, logic [36:0] secs,
                                      bit use_exchange);
    tick_t t;
    t.symbol_id = sym;
    t.price = px;
    t.cumulative_volume = cum;
    if (use_exchange) begin
      t.exchange_ms = 47'(secs) * 47'd1000 + 47'($urandom_range(999));
      t.wall_seconds = 37'({$urandom, $urandom});
    end else begin
      t.exchange_ms = '0;
      t.wall_seconds = secs;
    end
    return t;
  endfunction

  function automatic tick_t random_tick(int sym_span);
    tick_t t;
    int r;
    logic [5:0] sym;
    logic [47:0] cum;
    sym = (sym_span >= 64 && $urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                      : 6'($urandom_range(sym_span - 1));
    r = $urandom_range(99);
    if (r < 70) market_secs = market_secs + 37'($urandom_range(0, 40));
    else if (r < 80) market_secs = market_secs - 37'($urandom_range(0, 200));
    else market_secs = market_secs + 37'($urandom_range(0, 5000));
    r = $urandom_range(99);
    if (r < 75) day_volume[sym] = day_volume[sym] + 48'($urandom_range(0, 1000));
    else if (r < 85) day_volume[sym] = day_volume[sym] - 48'($urandom_range(0, 500));
    else if (r < 90) day_volume[sym] = 48'({$urandom, $urandom});
    cum = (r >= 90 && r < 97) ? 48'd0 : day_volume[sym];
    t = make_tick(sym, $urandom_range(9000, 11000), cum, market_secs,
                  1'($urandom_range(1)));
    // A little noise over the whole range of the price and both time fields.
    if ($urandom_range(19) == 0) begin
      t.price = $urandom;
      t.exchange_ms = ($urandom_range(1) == 0) ? 47'd0 : 47'({$urandom, $urandom});
      t.wall_seconds = 37'({$urandom, $urandom});
    end
    return t;
  endfunction

  task automatic run_random(int count, int sym_span);
    repeat (count) send_tick(random_tick(sym_span));
  endtask

  task automatic test_directed();
    send_tick(make_tick(6'd0, 32'd100, 48'd0, 37'd1000, 1'b0));        // first tick, no volume
    send_tick(make_tick(6'd0, 32'd100, 48'd50, 37'd1000, 1'b0));       // stored volume zero
    send_tick(make_tick(6'd0, 32'hFFFF_FFFF, 48'd80, 37'd1001, 1'b1));
    send_tick(make_tick(6'd0, 32'd0, 48'd0, 37'd1002, 1'b0));          // volume missing
    send_tick(make_tick(6'd0, 32'd7, 48'd60, 37'd1003, 1'b0));         // volume went down
    send_tick(make_tick(6'd0, 32'd8, 48'd1, 37'd1030, 1'b0));
    send_tick(make_tick(6'd0, 32'd9, VOL_MAX, 37'd1031, 1'b0));
    send_tick(make_tick(6'd0, 32'd9, 48'd1, 37'd1032, 1'b0));
    send_tick(make_tick(6'd0, 32'd9, VOL_MAX, 37'd1033, 1'b0));        // bar volume saturates
    send_tick(make_tick(6'd0, 32'd5, 48'd2, 37'd900, 1'b1));           // older tick
    send_tick(make_tick(6'd0, 32'd6, 48'd3, 37'd5000, 1'b0));          // closes frame 0 bar
    send_tick(make_tick(6'd63, 32'd1, VOL_MAX, SECS_MAX, 1'b0));
    send_tick(make_tick(6'd63, 32'hFFFF_FFFF, VOL_MAX, SECS_MAX, 1'b0));
    send_tick('{symbol_id: 6'd63, price: 32'd3, cumulative_volume: 48'd4,
                exchange_ms: 47'h7FFF_FFFF_FFFF, wall_seconds: 37'd0}); // seconds saturate
    send_tick('{symbol_id: 6'd63, price: 32'd3, cumulative_volume: 48'd4,
                exchange_ms: 47'd999, wall_seconds: SECS_MAX});        // time zero
    send_tick(make_tick(6'd42, 32'd3, 48'hAAAA_AAAA_AAAA, 37'd7, 1'b0));
    send_tick(make_tick(6'd21, 32'd3, 48'h5555_5555_5555, 37'd7, 1'b0));
    wait_idle();
    write_reg(REG_SYMBOLS, DUR_W'(30));
    send_tick(make_tick(6'd30, 32'd3, 48'd9, 37'd8, 1'b0));            // unknown symbol
    send_tick(make_tick(6'd63, 32'd3, 48'd9, 37'd8, 1'b0));
    send_tick(make_tick(6'd0, 32'd3, 48'd90, 37'd8000, 1'b0));
    wait_idle();
  endtask

  task automatic test_short_frames();
    write_reg(REG_SYMBOLS, DUR_W'(64));
    write_frames(1, 2, 3, 5, 7);
    run_random(70, 8);
    wait_idle();
  endtask

  task automatic test_long_and_zero_frames();
    write_reg(REG_SYMBOLS, DUR_W'(1));
    write_frames(86400, 86400, 0, 86400, 0);
    run_random(50, 64);
    wait_idle();
  endtask

  task automatic test_no_symbols();
    write_reg(REG_SYMBOLS, DUR_W'(0));
    run_random(12, 64);
    wait_idle();
  endtask

  task automatic test_mixed_frames();
    write_reg(REG_SYMBOLS, DUR_W'(33));
    write_frames(60, 17'h1FFFF, 1, 900, 86400);
    run_random(90, 64);
    wait_idle();
  endtask

  task automatic test_default_frames();
    write_reg(REG_SYMBOLS, DUR_W'(64));
    write_frames(60, 180, 300, 900, 1800);
    run_random(90, 12);
    idle_on = 1'b0;
    run_random(90, 64);
    wait_idle();
  endtask

  initial begin
    symbols_used = 7'd64;
    frame_dur = '{17'd60, 17'd180, 17'd300, 17'd900, 17'd1800};
    foreach (day_volume[i]) day_volume[i] = 48'd1000 * 48'(i);
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_short_frames();
    test_long_and_zero_frames();
    test_no_symbols();
    test_mixed_frames();
    test_default_frames();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tohlcv_pkg.sv
sv/tohlcv_ram.sv
sv/tick_to_ohlcv_bar_aggregator_top.sv
sim/tick_to_ohlcv_bar_aggregator_top_tb.sv
